// ----- design/sorted_tile_occupancy_table_assert.svh -----
// ----------------------------------------------------------------------------
// Sorted tile occupancy table: assertion macros
// Shared wrappers for the concurrent checks that the table's modules carry.
// ----------------------------------------------------------------------------
`ifndef SORTED_TILE_OCCUPANCY_TABLE_ASSERT_SVH
`define SORTED_TILE_OCCUPANCY_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STO_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define STO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/sto_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted tile occupancy table: package
// Field widths, codes, word types and the controller/datapath interface.
// ----------------------------------------------------------------------------
package sto_pkg;

  // Default grid size.
  localparam int MAX_WIDTH_DEF  = 64;
  localparam int MAX_HEIGHT_DEF = 64;

  // Field widths.
  localparam int ACTION_W   = 2;
  localparam int COORD_W    = 6;
  localparam int ID_W       = 29;
  localparam int FLAGS_W    = 3;
  localparam int TILE_W     = ID_W + FLAGS_W;
  localparam int STATUS_W   = 2;
  localparam int CHANGE_W   = 2;
  localparam int RANK_W     = 12;
  localparam int COUNT_W    = 13;
  localparam int DIM_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 29;

  // Actions.
  localparam logic [ACTION_W-1:0] ACT_READ   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_SET    = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RANGE  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_ID = 2'd2;

  // Change codes.
  localparam logic [CHANGE_W-1:0] CHG_NONE     = 2'd0;
  localparam logic [CHANGE_W-1:0] CHG_INSERTED = 2'd1;
  localparam logic [CHANGE_W-1:0] CHG_REPLACED = 2'd2;
  localparam logic [CHANGE_W-1:0] CHG_REMOVED  = 2'd3;

  // Configuration register indexes and reset values.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_FIRST_ID = 2'd2;
  localparam logic [DIM_W-1:0]     WIDTH_RST        = 7'd64;
  localparam logic [DIM_W-1:0]     HEIGHT_RST       = 7'd64;
  localparam logic [ID_W-1:0]      FIRST_ID_RST     = 29'd1;

  // Input word.
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [COORD_W-1:0]  col;
    logic [COORD_W-1:0]  row;
    logic [ID_W-1:0]     tile_id;
    logic [FLAGS_W-1:0]  flip_flags;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [CHANGE_W-1:0] change;
    logic [RANK_W-1:0]   rank;
    logic [ID_W-1:0]     read_id;
    logic [FLAGS_W-1:0]  read_flags;
    logic [COUNT_W-1:0]  occupied_count;
  } out_word_t;

  // What the list walk has to do for the current word.
  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_FIND,
    MODE_REMOVE,
    MODE_INSERT
  } mode_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_step;
    logic load;
    logic calc;
    logic grid_read;
    logic decide;
    logic scan_init;
    logic scan_step;
    logic place;
    logic commit;
  } sto_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic  clear_last;
    logic  range_bad;
    mode_t mode;
    logic  list_empty;
    logic  scan_done;
  } sto_stat_t;

endpackage

// ----- design/sorted_tile_occupancy_table.sv -----
// ----------------------------------------------------------------------------
// Sorted tile occupancy table
// Grid of tile words with a sorted list of occupied positions.
// ----------------------------------------------------------------------------
// After reset the block sweeps the tile grid to empty, one cell per cycle
// over all MAX_WIDTH * MAX_HEIGHT cells (4096 by default), with busy high. A
// word is taken when start is high and busy is low. The sorted position list
// sits in a single-port-write memory, and finding a rank, opening a gap on
// insert or closing it on removal walks that list one entry per cycle. Words
// that fail the position check skip the decode and the list walk and go
// straight to the commit. Each result word appears on out_word with
// out_valid high for exactly one cycle and must be taken then, since the
// receiver cannot stall the block. Configuration writes take effect at once
// and belong in idle periods.
// ----------------------------------------------------------------------------
module sorted_tile_occupancy_table #(
  parameter int MAX_WIDTH  = sto_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = sto_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  sto_pkg::in_word_t               in_word,
  output logic                            out_valid,
  output sto_pkg::out_word_t              out_word,
  input  logic                            cfg_we,
  input  logic [sto_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sto_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  logic [sto_pkg::DIM_W-1:0] layer_width_r;
  logic [sto_pkg::DIM_W-1:0] layer_height_r;
  logic [sto_pkg::ID_W-1:0]  first_tile_id_r;
  sto_pkg::sto_cmd_t         cmd;
  sto_pkg::sto_stat_t        stat;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layer_width_r   <= sto_pkg::WIDTH_RST;
      layer_height_r  <= sto_pkg::HEIGHT_RST;
      first_tile_id_r <= sto_pkg::FIRST_ID_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sto_pkg::CFG_IDX_WIDTH:    layer_width_r   <= cfg_wdata[sto_pkg::DIM_W-1:0];
        sto_pkg::CFG_IDX_HEIGHT:   layer_height_r  <= cfg_wdata[sto_pkg::DIM_W-1:0];
        sto_pkg::CFG_IDX_FIRST_ID: first_tile_id_r <= cfg_wdata[sto_pkg::ID_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer.
  sto_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .stat  (stat)
  );

  // Memories, list walker and result word.
  sto_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_word       (in_word),
    .layer_width   (layer_width_r),
    .layer_height  (layer_height_r),
    .first_tile_id (first_tile_id_r),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_word      (out_word)
  );

endmodule

// ----- design/sto_ctrl.sv -----
// ----------------------------------------------------------------------------
// Sorted tile occupancy table: controller
// Sequences the clearing pass, the grid lookup, the list walk and the commit.
// ----------------------------------------------------------------------------
`include "sorted_tile_occupancy_table_assert.svh"

module sto_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  output sto_pkg::sto_cmd_t  cmd,
  input  sto_pkg::sto_stat_t stat
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CALC,
    S_GRID_RD,
    S_DECIDE,
    S_SETUP,
    S_SCAN,
    S_PLACE,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  // State register and registered busy flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      busy_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

  // Next state and datapath commands.
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = S_GRID_RD;
      end
      S_GRID_RD: begin
        cmd.grid_read = 1'b1;
        state_nxt     = stat.range_bad ? S_FINISH : S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = S_SETUP;
      end
      S_SETUP: begin
        cmd.scan_init = 1'b1;
        priority if (stat.mode == sto_pkg::MODE_NONE) begin
          state_nxt = S_FINISH;
        end else if (stat.mode == sto_pkg::MODE_INSERT && stat.list_empty) begin
          state_nxt = S_PLACE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) begin
          state_nxt = (stat.mode == sto_pkg::MODE_INSERT) ? S_PLACE : S_FINISH;
        end
      end
      S_PLACE: begin
        cmd.place = 1'b1;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        cmd.commit = 1'b1;
        state_nxt  = S_IDLE;
      end
    endcase
  end

  // An accepted word keeps the block busy until its result is committed.
  `STO_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accepted word did not raise busy")
  // At most one datapath command is active in any cycle.
  `STO_ASSERT_NOW(a_cmd_onehot, clk, rst_n, 1'b1, $onehot0(cmd), "overlapping datapath commands")
  // The list is only written with a new position when inserting.
  `STO_ASSERT_NOW(a_place_insert, clk, rst_n, state_r == S_PLACE, stat.mode == sto_pkg::MODE_INSERT, "place outside an insert")

endmodule

// ----- design/sto_datapath.sv -----
// ----------------------------------------------------------------------------
// Sorted tile occupancy table: datapath
// Tile grid and sorted position list memories, list walker and result word.
// ----------------------------------------------------------------------------
`include "sorted_tile_occupancy_table_assert.svh"

module sto_datapath #(
  parameter int MAX_WIDTH  = sto_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = sto_pkg::MAX_HEIGHT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  sto_pkg::in_word_t              in_word,
  input  logic [sto_pkg::DIM_W-1:0]      layer_width,
  input  logic [sto_pkg::DIM_W-1:0]      layer_height,
  input  logic [sto_pkg::ID_W-1:0]       first_tile_id,
  input  sto_pkg::sto_cmd_t              cmd,
  output sto_pkg::sto_stat_t             stat,
  output logic                           out_valid,
  output sto_pkg::out_word_t             out_word
);

  localparam int GRID_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int PW         = $clog2(GRID_DEPTH);
  localparam int CW         = $clog2(GRID_DEPTH + 1);
  localparam int MUL_W      = sto_pkg::COORD_W + sto_pkg::DIM_W + 1;
  localparam int LIN_W      = (PW > MUL_W) ? PW : MUL_W;
  localparam int DIM_W      = sto_pkg::DIM_W;
  localparam int ID_W       = sto_pkg::ID_W;
  localparam int TILE_W     = sto_pkg::TILE_W;

  // Memories.
  logic [TILE_W-1:0] grid_mem [GRID_DEPTH];
  logic [PW-1:0]     list_mem [GRID_DEPTH];

  // Payload registers.
  sto_pkg::in_word_t  item_r;
  sto_pkg::out_word_t out_word_r;
  logic [PW-1:0]      pos_r;
  logic [TILE_W-1:0]  grid_q_r;
  logic [PW-1:0]      list_q_r;

  // Control registers.
  logic [CW-1:0]      count_r;
  logic [PW-1:0]      clr_idx_r;
  logic               out_valid_r;
  logic               range_bad_r;
  logic               id_bad_r;
  logic               replace_r;
  sto_pkg::mode_t     mode_r;
  logic [CW-1:0]      rd_idx_r;
  logic               issue_r;
  logic               ev_valid_r;
  logic [CW-1:0]      ev_idx_r;
  logic               found_r;
  logic [PW-1:0]      rank_r;
  logic [PW-1:0]      place_idx_r;

  // Effective layer size and linear position.
  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;
  logic [LIN_W-1:0] lin_pos;
  logic             range_bad;

  always_comb begin
    w_eff = (int'(layer_width) < MAX_WIDTH) ? layer_width : DIM_W'(MAX_WIDTH);
    h_eff = (int'(layer_height) < MAX_HEIGHT) ? layer_height : DIM_W'(MAX_HEIGHT);
    lin_pos = LIN_W'(item_r.col) + LIN_W'(item_r.row) * LIN_W'(w_eff);
    range_bad = (DIM_W'(item_r.col) >= w_eff) || (DIM_W'(item_r.row) >= h_eff);
  end

  // Decode of the stored word against the requested action.
  logic [ID_W-1:0]           cur_id;
  logic [sto_pkg::FLAGS_W-1:0] cur_fl;
  logic [TILE_W-1:0]         new_word;
  logic                      occ;
  logic                      is_set;
  logic                      id_zero;
  logic                      id_bad;
  logic                      is_del;
  logic                      replace_now;
  sto_pkg::mode_t            mode_now;

  always_comb begin
    cur_id   = grid_q_r[ID_W-1:0];
    cur_fl   = grid_q_r[TILE_W-1:ID_W];
    new_word = {item_r.flip_flags, item_r.tile_id};
    occ      = (cur_id != '0);
    is_set   = (item_r.action == sto_pkg::ACT_SET);
    id_zero  = (item_r.tile_id == '0);
    id_bad   = is_set && !id_zero && (item_r.tile_id < first_tile_id);
    is_del   = (item_r.action == sto_pkg::ACT_REMOVE) || (is_set && id_zero);
    replace_now = !id_bad && is_set && !id_zero && occ && (new_word != grid_q_r);
    priority if (id_bad) begin
      mode_now = occ ? sto_pkg::MODE_FIND : sto_pkg::MODE_NONE;
    end else if (is_del && occ) begin
      mode_now = sto_pkg::MODE_REMOVE;
    end else if (is_set && !id_zero && !occ) begin
      mode_now = sto_pkg::MODE_INSERT;
    end else if (occ) begin
      mode_now = sto_pkg::MODE_FIND;
    end else begin
      mode_now = sto_pkg::MODE_NONE;
    end
  end

  // List walk: one entry read per cycle, evaluated in the following cycle.
  logic          scan_up;
  logic          issue_last;
  logic          ev_active;
  logic          ev_match;
  logic          ev_greater;
  logic          ev_last;
  logic          scan_hit;
  logic          scan_end;
  logic          shift_we;
  logic [PW-1:0] shift_addr;

  always_comb begin
    scan_up    = (mode_r != sto_pkg::MODE_INSERT);
    issue_last = scan_up ? (rd_idx_r == count_r - CW'(1)) : (rd_idx_r == '0);
    ev_active  = cmd.scan_step && ev_valid_r;
    ev_match   = (list_q_r == pos_r);
    ev_greater = (list_q_r > pos_r);
    ev_last    = (ev_idx_r == count_r - CW'(1));
    scan_hit   = 1'b0;
    scan_end   = 1'b0;
    shift_we   = 1'b0;
    shift_addr = '0;
    unique case (mode_r)
      sto_pkg::MODE_NONE: begin
        scan_end = 1'b1;
      end
      sto_pkg::MODE_FIND: begin
        scan_hit = ev_match;
        scan_end = ev_match || ev_last;
      end
      sto_pkg::MODE_REMOVE: begin
        // Entries past the removed one move down by one place.
        scan_hit   = !found_r && ev_match;
        shift_we   = found_r;
        shift_addr = ev_idx_r[PW-1:0] - PW'(1);
        scan_end   = ev_last;
      end
      sto_pkg::MODE_INSERT: begin
        // Walking down, larger entries move up until the gap is found.
        shift_we   = ev_greater;
        shift_addr = ev_idx_r[PW-1:0] + PW'(1);
        scan_end   = !ev_greater || (ev_idx_r == '0);
      end
    endcase
  end

  // List write port.
  logic          list_we;
  logic [PW-1:0] list_waddr;
  logic [PW-1:0] list_wdata;

  always_comb begin
    list_we    = (ev_active && shift_we) || cmd.place;
    list_waddr = cmd.place ? place_idx_r : shift_addr;
    list_wdata = cmd.place ? pos_r : list_q_r;
  end

  // Grid write port, shared by the clearing pass and the commit.
  logic              grid_we;
  logic [PW-1:0]     grid_waddr;
  logic [TILE_W-1:0] grid_wdata;
  logic              commit_we;

  always_comb begin
    commit_we = (mode_r == sto_pkg::MODE_REMOVE) || (mode_r == sto_pkg::MODE_INSERT) ||
                replace_r;
    grid_we    = cmd.clear_step || (cmd.commit && commit_we);
    grid_waddr = cmd.clear_step ? clr_idx_r : pos_r;
    grid_wdata = (cmd.clear_step || mode_r == sto_pkg::MODE_REMOVE) ? '0 : new_word;
  end

  // List length after the action.
  logic [CW-1:0] count_after;

  always_comb begin
    unique case (mode_r)
      sto_pkg::MODE_REMOVE: count_after = count_r - CW'(1);
      sto_pkg::MODE_INSERT: count_after = count_r + CW'(1);
      sto_pkg::MODE_NONE,
      sto_pkg::MODE_FIND:   count_after = count_r;
    endcase
  end

  // Result word.
  sto_pkg::out_word_t res_word;

  always_comb begin
    if (range_bad_r) begin
      res_word.status = sto_pkg::STATUS_RANGE;
    end else if (id_bad_r) begin
      res_word.status = sto_pkg::STATUS_BAD_ID;
    end else begin
      res_word.status = sto_pkg::STATUS_OK;
    end
    unique case (mode_r)
      sto_pkg::MODE_REMOVE: res_word.change = sto_pkg::CHG_REMOVED;
      sto_pkg::MODE_INSERT: res_word.change = sto_pkg::CHG_INSERTED;
      sto_pkg::MODE_NONE,
      sto_pkg::MODE_FIND:
        res_word.change = replace_r ? sto_pkg::CHG_REPLACED : sto_pkg::CHG_NONE;
    endcase
    res_word.rank           = sto_pkg::RANK_W'(rank_r);
    res_word.read_id        = range_bad_r ? '0 : cur_id;
    res_word.read_flags     = range_bad_r ? '0 : cur_fl;
    res_word.occupied_count = sto_pkg::COUNT_W'(count_after);
  end

  // Memories and payload registers.
  always_ff @(posedge clk) begin
    if (grid_we) begin
      grid_mem[grid_waddr] <= grid_wdata;
    end
    if (cmd.grid_read) begin
      grid_q_r <= grid_mem[pos_r];
    end
    if (list_we) begin
      list_mem[list_waddr] <= list_wdata;
    end
    if (cmd.scan_step && issue_r) begin
      list_q_r <= list_mem[rd_idx_r[PW-1:0]];
    end
    if (cmd.load) begin
      item_r <= in_word;
    end
    if (cmd.calc) begin
      pos_r <= lin_pos[PW-1:0];
    end
    if (cmd.commit) begin
      out_word_r <= res_word;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
      range_bad_r <= 1'b0;
      id_bad_r    <= 1'b0;
      replace_r   <= 1'b0;
      mode_r      <= sto_pkg::MODE_NONE;
      rd_idx_r    <= '0;
      issue_r     <= 1'b0;
      ev_valid_r  <= 1'b0;
      ev_idx_r    <= '0;
      found_r     <= 1'b0;
      rank_r      <= '0;
      place_idx_r <= '0;
    end else begin
      out_valid_r <= cmd.commit;
      if (cmd.clear_step) begin
        clr_idx_r <= clr_idx_r + PW'(1);
      end
      // A fresh word starts with no list work and rank zero.
      if (cmd.calc) begin
        range_bad_r <= range_bad;
        id_bad_r    <= 1'b0;
        replace_r   <= 1'b0;
        mode_r      <= sto_pkg::MODE_NONE;
        rank_r      <= '0;
      end
      if (cmd.decide) begin
        id_bad_r  <= id_bad;
        replace_r <= replace_now;
        mode_r    <= mode_now;
      end
      if (cmd.scan_init) begin
        ev_valid_r  <= 1'b0;
        found_r     <= 1'b0;
        place_idx_r <= '0;
        if (mode_r == sto_pkg::MODE_INSERT) begin
          rd_idx_r <= count_r - CW'(1);
          issue_r  <= (count_r != '0);
        end else begin
          rd_idx_r <= '0;
          issue_r  <= 1'b1;
        end
      end
      if (cmd.scan_step) begin
        ev_valid_r <= issue_r;
        if (issue_r) begin
          ev_idx_r <= rd_idx_r;
          rd_idx_r <= scan_up ? rd_idx_r + CW'(1) : rd_idx_r - CW'(1);
          issue_r  <= !issue_last;
        end
        if (ev_valid_r && scan_hit) begin
          found_r <= 1'b1;
          rank_r  <= ev_idx_r[PW-1:0];
        end
        if (ev_valid_r && mode_r == sto_pkg::MODE_INSERT && !ev_greater) begin
          place_idx_r <= ev_idx_r[PW-1:0] + PW'(1);
        end
      end
      if (cmd.place) begin
        rank_r <= place_idx_r;
      end
      if (cmd.commit) begin
        count_r <= count_after;
      end
    end
  end

  // Status to the controller.
  always_comb begin
    stat.clear_last = (clr_idx_r == PW'(GRID_DEPTH - 1));
    stat.range_bad  = range_bad_r;
    stat.mode       = mode_r;
    stat.list_empty = (count_r == '0);
    stat.scan_done  = ev_active && scan_end;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // The list never holds more entries than the grid has cells.
  `STO_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(GRID_DEPTH), "list count beyond grid size")
  // Each result word is strobed for a single cycle.
  `STO_ASSERT_NEXT(a_out_pulse, clk, rst_n, out_valid_r, !out_valid_r, "result strobe held")
  // Committing an insert grows the list by exactly one entry.
  `STO_ASSERT_NEXT(a_insert_count, clk, rst_n, cmd.commit && mode_r == sto_pkg::MODE_INSERT, count_r == $past(count_r) + CW'(1), "insert did not grow the list")

endmodule
